// File: hw/rtl/hsl2rgb_pkg.sv
// Package for the HSL to RGB converter: transaction structs, arithmetic
// constants and the hue ramp helpers. No dependencies.
package hsl2rgb_pkg;

    // Input transaction: hue, saturation, lightness
    typedef struct packed {
        logic [9:0] hue_degrees;
        logic [6:0] saturation_pct;
        logic [6:0] lightness_pct;
    } t_hsl_in;

    // Output transaction: 8-bit channel levels
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_rgb_out;

    localparam int unsigned NUM_CHAN = 3;

    localparam logic [9:0]  HUE_CIRCLE   = 10'd360;
    localparam logic [9:0]  HUE_CIRCLE_2 = 10'd720;
    localparam logic [8:0]  HUE_THIRD    = 9'd120;
    localparam logic [8:0]  HUE_TWO_THIRD = 9'd240;
    localparam logic [8:0]  HUE_SIXTH    = 9'd60;
    localparam logic [8:0]  HUE_HALF     = 9'd180;
    localparam logic [6:0]  PCT_MAX      = 7'd100;
    localparam logic [6:0]  PCT_HALF     = 7'd50;
    localparam logic [14:0] LIGHT_SCALE  = 15'd200;
    localparam logic [19:0] RAMP_MAX     = 20'd600000;
    localparam logic [13:0] HELPER_MAX   = 14'd10000;

    // ramp * 255 / 600000 == ramp * 17 / 40000 == ((ramp * 17) >> 6) / 625.
    // Division by 625 is a multiply by ceil(2^28 / 625) and a shift; exact
    // for dividends below 2^18.
    localparam logic [18:0] RECIP_625    = 19'd429497;
    localparam int unsigned RECIP_SHIFT  = 28;
    localparam logic [17:0] QUOT_IN_MAX  = 18'd159375;

    // Hue in 0..1023 reduced into 0..359
    function automatic logic [8:0] wrap_hue(input logic [9:0] hue);
        logic [9:0] w;
        if (hue >= HUE_CIRCLE_2) begin
            w = hue - HUE_CIRCLE_2;
        end else if (hue >= HUE_CIRCLE) begin
            w = hue - HUE_CIRCLE;
        end else begin
            w = hue;
        end
        return w[8:0];
    endfunction

    // Ramp weight over a hue in 0..359: ramp = low*60 + (high-low)*weight
    function automatic logic [5:0] ramp_weight(input logic [8:0] hue);
        logic [8:0] w;
        if (hue < HUE_SIXTH) begin
            w = hue;
        end else if (hue < HUE_HALF) begin
            w = HUE_SIXTH;
        end else if (hue < HUE_TWO_THIRD) begin
            w = HUE_TWO_THIRD - hue;
        end else begin
            w = '0;
        end
        return w[5:0];
    endfunction

endpackage

// File: hw/rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter top level: six-stage pipeline, integer math.
// Depends on hsl2rgb_pkg for transaction types, constants and hue helpers.
// The output is taken from the last of the six register stages.
// Throughput: one transaction per cycle while the output is not stalled; empty stages fill while output stalls.
// Reset (synchronous, active low) clears the stage valid bits only.
// The final stage is the output register.
module hsl_to_rgb_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  hsl2rgb_pkg::t_hsl_in   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output hsl2rgb_pkg::t_rgb_out  o_out_data
);

    localparam int unsigned NSTAGE = 6;
    localparam int unsigned NCH    = hsl2rgb_pkg::NUM_CHAN;

    // Stage valid bits and per-stage advance
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] w_adv;

    // Stage 1: wrapped hue, clamped percents
    logic [8:0]  r_s1_hue;
    logic [6:0]  r_s1_sat;
    logic [6:0]  r_s1_light;
    // Stage 2: helper high, lightness*200, ramp weights
    logic [13:0] r_s2_high;
    logic [14:0] r_s2_l200;
    logic [5:0]  r_s2_wt [NCH];
    // Stage 3: low*60, high-low, weights
    logic [19:0] r_s3_low60;
    logic [13:0] r_s3_diff;
    logic [5:0]  r_s3_wt [NCH];
    // Stage 4: channel ramps
    logic [19:0] r_s4_ramp [NCH];
    // Stage 5: ramp*17/64
    logic [17:0] r_s5_quot [NCH];
    // Stage 6: output levels
    logic [7:0]  r_s6_level [NCH];

    // Handshake: a stage advances when empty or when the next one advances
    always_comb begin
        w_adv[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_stall  = !w_adv[0];
    assign o_out_valid = r_vld[NSTAGE-1];
    assign o_out_data  = '{red_level:   r_s6_level[0],
                           green_level: r_s6_level[1],
                           blue_level:  r_s6_level[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1 logic: hue wrap and percent clamp
    logic [8:0] n_s1_hue;
    logic [6:0] n_s1_sat;
    logic [6:0] n_s1_light;

    always_comb begin
        n_s1_hue   = hsl2rgb_pkg::wrap_hue(i_in_data.hue_degrees);
        n_s1_sat   = (i_in_data.saturation_pct > hsl2rgb_pkg::PCT_MAX) ?
                     hsl2rgb_pkg::PCT_MAX : i_in_data.saturation_pct;
        n_s1_light = (i_in_data.lightness_pct > hsl2rgb_pkg::PCT_MAX) ?
                     hsl2rgb_pkg::PCT_MAX : i_in_data.lightness_pct;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_hue   <= n_s1_hue;
            r_s1_sat   <= n_s1_sat;
            r_s1_light <= n_s1_light;
        end
    end

    // Stage 2 logic: helper high value, lightness*200, channel hues and ramp weights
    logic [14:0] w_s2_l;
    logic [14:0] w_s2_s;
    logic [14:0] w_s2_dark;
    logic [14:0] w_s2_bright;
    logic [8:0]  w_s2_hue [NCH];
    logic [13:0] n_s2_high;
    logic [14:0] n_s2_l200;

    always_comb begin
        w_s2_l      = 15'(r_s1_light);
        w_s2_s      = 15'(r_s1_sat);
        w_s2_dark   = w_s2_l * (15'(hsl2rgb_pkg::PCT_MAX) + w_s2_s);
        w_s2_bright = (w_s2_l + w_s2_s) * 15'(hsl2rgb_pkg::PCT_MAX) - w_s2_s * w_s2_l;
        n_s2_high   = (r_s1_light < hsl2rgb_pkg::PCT_HALF) ?
                      w_s2_dark[13:0] : w_s2_bright[13:0];
        n_s2_l200   = w_s2_l * hsl2rgb_pkg::LIGHT_SCALE;
        // red leads by 120 degrees, blue lags by 120
        w_s2_hue[0] = (r_s1_hue < hsl2rgb_pkg::HUE_TWO_THIRD) ?
                      r_s1_hue + hsl2rgb_pkg::HUE_THIRD :
                      r_s1_hue - hsl2rgb_pkg::HUE_TWO_THIRD;
        w_s2_hue[1] = r_s1_hue;
        w_s2_hue[2] = (r_s1_hue >= hsl2rgb_pkg::HUE_THIRD) ?
                      r_s1_hue - hsl2rgb_pkg::HUE_THIRD :
                      r_s1_hue + hsl2rgb_pkg::HUE_TWO_THIRD;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_high <= n_s2_high;
            r_s2_l200 <= n_s2_l200;
            for (int c = 0; c < NCH; c++) begin
                r_s2_wt[c] <= hsl2rgb_pkg::ramp_weight(w_s2_hue[c]);
            end
        end
    end

    // Stage 3 logic: low helper, ramp base and slope
    logic [14:0] w_s3_high;
    logic [14:0] w_s3_low;
    logic [14:0] w_s3_diff;
    logic [19:0] n_s3_low60;

    always_comb begin
        w_s3_high  = 15'(r_s2_high);
        w_s3_low   = r_s2_l200 - w_s3_high;
        w_s3_diff  = (w_s3_high + w_s3_high) - r_s2_l200;
        n_s3_low60 = 20'(w_s3_low) * 20'(hsl2rgb_pkg::HUE_SIXTH);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_low60 <= n_s3_low60;
            r_s3_diff  <= w_s3_diff[13:0];
            r_s3_wt    <= r_s2_wt;
        end
    end

    // Stage 4: per-channel ramp = low*60 + (high-low)*weight
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int c = 0; c < NCH; c++) begin
                r_s4_ramp[c] <= r_s3_low60 + 20'(r_s3_diff) * 20'(r_s3_wt[c]);
            end
        end
    end

    // Stage 5: ramp*17 by shift-add, then drop six bits
    logic [23:0] w_s5_x17 [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_s5_x17[c] = {r_s4_ramp[c], 4'b0000} + 24'(r_s4_ramp[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int c = 0; c < NCH; c++) begin
                r_s5_quot[c] <= w_s5_x17[c][23:6];
            end
        end
    end

    // Stage 6: divide by 625 via reciprocal multiply
    logic [36:0] w_s6_prod [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_s6_prod[c] = 37'(r_s5_quot[c]) * 37'(hsl2rgb_pkg::RECIP_625);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int c = 0; c < NCH; c++) begin
                r_s6_level[c] <= w_s6_prod[c][hsl2rgb_pkg::RECIP_SHIFT +: 8];
            end
        end
    end

    // Helper values keep low <= high <= 10000
    a_helper_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_high <= hsl2rgb_pkg::HELPER_MAX) &&
                     (15'(r_s2_high) <= r_s2_l200) &&
                     (r_s2_l200 <= 15'(r_s2_high) + 15'(r_s2_high)))
        else $error("HSL helper values out of order");

    // Ramp weights never exceed one sixth of the circle
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_wt[0] <= 6'(hsl2rgb_pkg::HUE_SIXTH)) &&
                     (r_s2_wt[1] <= 6'(hsl2rgb_pkg::HUE_SIXTH)) &&
                     (r_s2_wt[2] <= 6'(hsl2rgb_pkg::HUE_SIXTH)))
        else $error("ramp weight above 60");

    // Ramps stay within the scale, so the quotient fits 8 bits
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_s4_ramp[0] <= hsl2rgb_pkg::RAMP_MAX) &&
                     (r_s4_ramp[1] <= hsl2rgb_pkg::RAMP_MAX) &&
                     (r_s4_ramp[2] <= hsl2rgb_pkg::RAMP_MAX))
        else $error("channel ramp above 600000");

    // Reciprocal divide is exact only below its input bound
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_s5_quot[0] <= hsl2rgb_pkg::QUOT_IN_MAX) &&
                     (r_s5_quot[1] <= hsl2rgb_pkg::QUOT_IN_MAX) &&
                     (r_s5_quot[2] <= hsl2rgb_pkg::QUOT_IN_MAX))
        else $error("divider input out of range");

    // A held output keeps the whole pipe from losing a full stage
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && i_out_stall |=> (&r_vld))
        else $error("full pipeline dropped a transaction under stall");

endmodule

// File: test/tb_hsl_to_rgb_converter.sv
// Testbench for hsl_to_rgb_converter: directed corner pixels, then random pixels,
// checked against an integer HSL to RGB predictor. Depends on hsl2rgb_pkg and the DUT.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned RANDOM_PIXELS = 1500;
    localparam int unsigned GAP_PCT       = 16;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned HOLD_AT       = 400;
    localparam int unsigned QUIET_FROM    = 800;
    localparam int unsigned QUIET_TO      = 1100;
    localparam int unsigned DRAIN_WAIT    = 20;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    localparam int unsigned DEG_CIRCLE = 360;
    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned LEVEL_TOP  = 255;
    localparam int unsigned RAMP_DIV   = 600000;

    // One queued pixel; drain_first holds it back until the pipe is empty
    typedef struct {
        hsl2rgb_pkg::t_hsl_in px;
        bit                   drain_first;
    } t_pixel_job;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    hsl2rgb_pkg::t_hsl_in  i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    hsl2rgb_pkg::t_rgb_out o_out_data;

    t_pixel_job             pending_px[$];
    hsl2rgb_pkg::t_rgb_out  expected_rgb[$];

    logic        in_fire;
    int unsigned accepted_cnt;
    int unsigned result_cnt;
    int unsigned error_cnt;
    int unsigned backpressure_cnt;
    int unsigned directed_cnt;
    int unsigned cycle_cnt;
    int unsigned hold_left;
    bit          hold_done;

    hsl_to_rgb_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Piecewise-linear ramp of one channel, scaled down to an 8-bit level
    function automatic logic [7:0] channel_level(input int unsigned lo, input int unsigned hi,
                                                 input int unsigned deg);
        int unsigned ramp;
        if (deg < 60) begin
            ramp = lo * 60 + (hi - lo) * deg;
        end else if (deg < 180) begin
            ramp = hi * 60;
        end else if (deg < 240) begin
            ramp = lo * 60 + (hi - lo) * (240 - deg);
        end else begin
            ramp = lo * 60;
        end
        return 8'((ramp * LEVEL_TOP) / RAMP_DIV);
    endfunction

    // Expected color of one pixel
    function automatic hsl2rgb_pkg::t_rgb_out hsl_to_rgb(input hsl2rgb_pkg::t_hsl_in px);
        int unsigned           hue;
        int unsigned           sat;
        int unsigned           lit;
        int unsigned           hi;
        int unsigned           lo;
        hsl2rgb_pkg::t_rgb_out rgb;
        hue = int'(px.hue_degrees) % DEG_CIRCLE;
        sat = (px.saturation_pct > PCT_FULL) ? PCT_FULL : px.saturation_pct;
        lit = (px.lightness_pct > PCT_FULL) ? PCT_FULL : px.lightness_pct;
        if (sat == 0) begin
            // grey: all channels equal
            rgb.red_level   = 8'(lit * LEVEL_TOP / PCT_FULL);
            rgb.green_level = rgb.red_level;
            rgb.blue_level  = rgb.red_level;
        end else begin
            if (lit < 50) begin
                hi = lit * (PCT_FULL + sat);
            end else begin
                hi = (lit + sat) * PCT_FULL - sat * lit;
            end
            lo = lit * 200 - hi;
            rgb.red_level   = channel_level(lo, hi, (hue < 240) ? hue + 120 : hue - 240);
            rgb.green_level = channel_level(lo, hi, hue);
            rgb.blue_level  = channel_level(lo, hi, (hue >= 120) ? hue - 120 : hue + 240);
        end
        return rgb;
    endfunction

    // Idle percentage, zero inside the quiet window
    function automatic int unsigned gap_percent();
        if (accepted_cnt >= QUIET_FROM && accepted_cnt < QUIET_TO) begin
            return 0;
        end
        return GAP_PCT;
    endfunction

    function automatic logic [9:0] pick_hue();
        logic [9:0] corners[12] = '{10'd0, 10'd59, 10'd60, 10'd119, 10'd120, 10'd180,
                                    10'd239, 10'd240, 10'd359, 10'd360, 10'd720, 10'd1023};
        if ($urandom_range(3) == 0) begin
            return corners[$urandom_range(11)];
        end
        return 10'($urandom_range(1023));
    endfunction

    function automatic logic [6:0] pick_pct();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            return 7'd0;
        end else if (roll < 24) begin
            return 7'($urandom_range(127, 100));
        end else if (roll < 32) begin
            return 7'($urandom_range(51, 49));
        end
        return 7'($urandom_range(127));
    endfunction

    task automatic add_pixel(input int unsigned hue, input int unsigned sat,
                             input int unsigned lit, input bit drain);
        t_pixel_job job;
        job.px.hue_degrees    = 10'(hue);
        job.px.saturation_pct = 7'(sat);
        job.px.lightness_pct  = 7'(lit);
        job.drain_first       = drain;
        pending_px.insert(pending_px.size(), job);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Known values from time zero, reset, stimulus queue
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_out_stall = 1'b0;
        in_fire    = 1'b0;
        accepted_cnt = 0;
        result_cnt   = 0;
        error_cnt    = 0;
        backpressure_cnt = 0;
        cycle_cnt  = 0;
        hold_left  = 0;
        hold_done  = 1'b0;

        // hue sector edges and wrap, grey, clamped percents, lightness split
        add_pixel(0, 100, 50, 1'b0);
        add_pixel(59, 100, 50, 1'b0);
        add_pixel(60, 100, 50, 1'b0);
        add_pixel(119, 80, 40, 1'b0);
        add_pixel(120, 80, 60, 1'b0);
        add_pixel(179, 50, 25, 1'b0);
        add_pixel(180, 50, 75, 1'b0);
        add_pixel(239, 100, 49, 1'b0);
        add_pixel(240, 100, 51, 1'b0);
        add_pixel(300, 1, 50, 1'b0);
        add_pixel(359, 127, 127, 1'b0);
        add_pixel(360, 100, 50, 1'b0);
        add_pixel(719, 60, 30, 1'b0);
        add_pixel(720, 60, 70, 1'b0);
        add_pixel(1023, 101, 50, 1'b0);
        add_pixel(1023, 127, 0, 1'b0);
        add_pixel(200, 0, 0, 1'b0);
        add_pixel(200, 0, 33, 1'b0);
        add_pixel(200, 0, 100, 1'b0);
        add_pixel(1023, 0, 127, 1'b0);
        add_pixel(90, 100, 100, 1'b0);
        add_pixel(90, 100, 0, 1'b0);
        add_pixel(45, 127, 1, 1'b0);
        add_pixel(500, 37, 99, 1'b0);
        directed_cnt = pending_px.size();

        // random pixels; two of them wait for an empty pipeline first
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            add_pixel(pick_hue(), pick_pct(), pick_pct(), (i == 0) || (i == 700));
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Pixel driver: loads a new transaction once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pending_px.size() != 0 && $urandom_range(99) >= gap_percent()
                && !(pending_px[0].drain_first && expected_rgb.size() != 0)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_px.pop_front().px;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random, plus one long hold-off to back the pipe up
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < gap_percent());
        end
    end

    // Monitor: check results first, then record newly accepted pixels
    always @(posedge i_clk) begin
        hsl2rgb_pkg::t_rgb_out want;
        in_fire <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_cnt++;
                if (expected_rgb.size() == 0) begin
                    $error("unexpected result: %h", o_out_data);
                    error_cnt++;
                end else begin
                    want = expected_rgb.pop_front();
                    if (o_out_data.red_level !== want.red_level) begin
                        $error("red_level: expected %0d, actual %0d",
                               want.red_level, o_out_data.red_level);
                        error_cnt++;
                    end
                    if (o_out_data.green_level !== want.green_level) begin
                        $error("green_level: expected %0d, actual %0d",
                               want.green_level, o_out_data.green_level);
                        error_cnt++;
                    end
                    if (o_out_data.blue_level !== want.blue_level) begin
                        $error("blue_level: expected %0d, actual %0d",
                               want.blue_level, o_out_data.blue_level);
                        error_cnt++;
                    end
                end
            end
            if (i_in_valid && o_in_stall) begin
                backpressure_cnt++;
            end
            if (i_in_valid && !o_in_stall) begin
                accepted_cnt++;
                expected_rgb.insert(expected_rgb.size(), hsl_to_rgb(i_in_data));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, expected_rgb.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // End of run
    initial begin
        @(posedge i_rst_n);
        while (pending_px.size() != 0 || i_in_valid || expected_rgb.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Converted %0d pixels (%0d directed corners, rest random), %0d results",
                 accepted_cnt, directed_cnt, result_cnt);
        $display("Input back-pressure seen on %0d cycles, %0d errors",
                 backpressure_cnt, error_cnt);
        if (error_cnt == 0 && expected_rgb.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
